// ----- rtl/scan_pkg.sv -----
// shared constants and types for the scan disk scheduler
package scan_pkg;

    // default store depth
    localparam int MAX_REQUESTS_DEF = 32;

    // field widths
    localparam int TRACK_W  = 16;
    localparam int SEEK_W   = 17;
    localparam int TCOUNT_W = 17;

    // stream data widths, padded to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_START_HEAD = 2'd0;
    localparam logic [1:0] REG_SWEEP_DOWN = 2'd1;
    localparam logic [1:0] REG_TRACK_CNT  = 2'd2;

    // register reset values
    localparam logic [TRACK_W-1:0]  START_HEAD_RST  = 16'd0;
    localparam logic [TCOUNT_W-1:0] TRACK_COUNT_RST = 17'd200;

    // far end clamps
    localparam logic [TCOUNT_W-1:0] TRACK_COUNT_MAX = 17'd65536;
    localparam logic [TRACK_W-1:0]  TRACK_MAX       = 16'hFFFF;

    // saturation limit of the seek total
    localparam logic [SEEK_W-1:0] SEEK_MAX = 17'h1FFFF;

    // controller states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_INS_RD    = 7'b0000010,
        ST_INS_CMP   = 7'b0000100,
        ST_WALK_INIT = 7'b0001000,
        ST_WALK_RD   = 7'b0010000,
        ST_WALK_EVAL = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

endpackage

// ----- rtl/scan_disk_scheduler.sv -----
// scan disk scheduler: sorted request memory, insertion and scan walk controller
// insertion: a request reads stored entries from the top down, shifts each larger one up a slot and is
// written in place, or in the lowest slot; the flagged last request then walks the sorted memory twice,
// once per sweep direction, and the final track is sent with last set when the output is free
// throughput: one request at a time, bounded by the single read port of the request memory
// reset: rst_n is asynchronous, clears the batch and loads register defaults; no clearing pass
module scan_disk_scheduler #(
    parameter int MAX_REQUESTS = scan_pkg::MAX_REQUESTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scan_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] request_track
    input  logic                              s_tlast,   // last_request
    // schedule stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scan_pkg::M_DATA_W-1:0]     m_tdata,   // [15:0] served_track, [32:16] seek_total
    output logic                              m_tlast,   // last_served
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scan_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scan_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scan_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import scan_pkg::*;

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_REQUESTS);

    // configuration registers
    logic [TRACK_W-1:0]  start_head_reg;
    logic                sweep_down_reg;
    logic [TCOUNT_W-1:0] track_count_reg;

    // request memory
    logic [TRACK_W-1:0] mem [MAX_REQUESTS];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TRACK_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [TRACK_W-1:0] rd_data_reg;

    // control state
    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic               ep_pend_reg, ep_pend_next;
    logic [TRACK_W-1:0] v_reg, v_next;
    logic               last_reg, last_next;
    logic [TRACK_W-1:0] head_reg, head_next;
    logic [SEEK_W-1:0]  acc_reg, acc_next;

    // pending visit, held until the next one proves it is not the final track
    logic               pend_valid_reg, pend_valid_next;
    logic [TRACK_W-1:0] pend_track_reg, pend_track_next;
    logic [SEEK_W-1:0]  pend_seek_reg, pend_seek_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [TRACK_W-1:0] out_track_reg, out_track_next;
    logic [SEEK_W-1:0]  out_seek_reg, out_seek_next;
    logic               out_last_reg, out_last_next;

    // helpers
    logic               cfg_wr;
    logic [TRACK_W-1:0] far_end;
    logic [TRACK_W-1:0] ep_track;
    logic               dir_up;
    logic               walk_end;
    logic               is_cand;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      j_m1;
    logic               out_free;
    logic               can_visit;
    logic               visit_en;
    logic [TRACK_W-1:0] visit_track;
    logic [TRACK_W-1:0] step_len;
    logic [SEEK_W:0]    seek_sum;
    logic [SEEK_W-1:0]  seek_sat;
    logic               push_en;
    logic               push_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_START_HEAD: prdata = APB_DATA_W'(start_head_reg);
            REG_SWEEP_DOWN: prdata = APB_DATA_W'(sweep_down_reg);
            REG_TRACK_CNT:  prdata = APB_DATA_W'(track_count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_head_reg  <= START_HEAD_RST;
            sweep_down_reg  <= 1'b0;
            track_count_reg <= TRACK_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_START_HEAD: start_head_reg  <= pwdata[TRACK_W-1:0];
                REG_SWEEP_DOWN: sweep_down_reg  <= pwdata[0];
                REG_TRACK_CNT:  track_count_reg <= pwdata[TCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // far end of the disk with clamps for zero and oversized counts
    always_comb
    begin
        if (track_count_reg == '0)
            far_end = '0;
        else if (track_count_reg > TRACK_COUNT_MAX)
            far_end = TRACK_MAX;
        else
            far_end = TRACK_W'(track_count_reg - 1'b1);
    end

    // sweep endpoint visited in the first phase
    assign ep_track = sweep_down_reg ? '0 : far_end;

    // walk direction: first phase goes toward the sweep endpoint, up unless sweep_down is set
    assign dir_up   = sweep_down_reg ? phase_reg : ~phase_reg;
    assign walk_end = dir_up ? (idx_reg == count_reg) : (idx_reg == '0);
    assign idx_m1   = idx_reg - 1'b1;
    assign j_m1     = j_reg - 1'b1;
    assign is_cand  = dir_up ? (rd_data_reg > start_head_reg) : (rd_data_reg < start_head_reg);

    // handshake status
    assign out_free  = ~out_valid_reg | m_tready;
    assign can_visit = ~pend_valid_reg | out_free;
    assign s_tready  = (state_reg == ST_IDLE);

    // head movement and saturating seek total for a visit
    assign step_len = (visit_track >= head_reg) ? (visit_track - head_reg)
                                                : (head_reg - visit_track);
    assign seek_sum = {1'b0, acc_reg} + (SEEK_W + 1)'(step_len);
    assign seek_sat = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

    // controller
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        ep_pend_next    = ep_pend_reg;
        v_next          = v_reg;
        last_next       = last_reg;
        head_next       = head_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_track_next = pend_track_reg;
        pend_seek_next  = pend_seek_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        visit_en        = 1'b0;
        visit_track     = '0;
        push_en         = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    v_next    = s_tdata[TRACK_W-1:0];
                    last_next = s_tlast;
                    j_next    = count_reg;
                    // full store drops the request, the flag still starts the schedule
                    if (count_reg == COUNT_FULL)
                        state_next = s_tlast ? ST_WALK_INIT : ST_IDLE;
                    else
                        state_next = ST_INS_RD;
                end
            end

            ST_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = v_reg;
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_WALK_INIT : ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_m1[AW-1:0];
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                // shift the larger entry up one slot, or drop the request in place
                if (rd_data_reg > v_reg)
                begin
                    mem_wdata  = rd_data_reg;
                    j_next     = j_m1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    mem_wdata  = v_reg;
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ST_WALK_INIT : ST_IDLE;
                end
            end

            ST_WALK_INIT:
            begin
                phase_next   = 1'b0;
                idx_next     = sweep_down_reg ? count_reg : '0;
                head_next    = start_head_reg;
                acc_next     = '0;
                ep_pend_next = 1'b1;
                state_next   = ST_WALK_RD;
            end

            ST_WALK_RD:
            begin
                if (walk_end)
                begin
                    if (!phase_reg)
                    begin
                        // endpoint not yet served goes last in the first phase
                        if (ep_pend_reg)
                        begin
                            if (can_visit)
                            begin
                                visit_en     = 1'b1;
                                visit_track  = ep_track;
                                ep_pend_next = 1'b0;
                            end
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            idx_next   = sweep_down_reg ? '0 : count_reg;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = dir_up ? idx_reg[AW-1:0] : idx_m1[AW-1:0];
                    state_next = ST_WALK_EVAL;
                end
            end

            ST_WALK_EVAL:
            begin
                if (is_cand)
                begin
                    // far end merged into the upward first phase in sorted position
                    if (!sweep_down_reg && !phase_reg && ep_pend_reg && (far_end <= rd_data_reg))
                    begin
                        if (can_visit)
                        begin
                            visit_en     = 1'b1;
                            visit_track  = far_end;
                            ep_pend_next = 1'b0;
                        end
                    end
                    else if (can_visit)
                    begin
                        visit_en    = 1'b1;
                        visit_track = rd_data_reg;
                        idx_next    = dir_up ? idx_reg + 1'b1 : idx_m1;
                        state_next  = ST_WALK_RD;
                    end
                end
                else
                begin
                    idx_next   = dir_up ? idx_reg + 1'b1 : idx_m1;
                    state_next = ST_WALK_RD;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    push_en         = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    head_next       = start_head_reg;
                    acc_next        = '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new visit moves the older pending track to the output
        if (visit_en)
        begin
            head_next       = visit_track;
            acc_next        = seek_sat;
            pend_valid_next = 1'b1;
            pend_track_next = visit_track;
            pend_seek_next  = seek_sat;
            push_en         = pend_valid_reg;
        end
    end

    // output register
    always_comb
    begin
        out_track_next = out_track_reg;
        out_seek_next  = out_seek_reg;
        out_last_next  = out_last_reg;
        if (push_en)
        begin
            out_valid_next = 1'b1;
            out_track_next = pend_track_reg;
            out_seek_next  = pend_seek_reg;
            out_last_next  = push_last;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - TRACK_W - SEEK_W){1'b0}}, out_seek_reg, out_track_reg};
    assign m_tlast  = out_last_reg;

    // request memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            j_reg          <= '0;
            idx_reg        <= '0;
            phase_reg      <= 1'b0;
            ep_pend_reg    <= 1'b0;
            v_reg          <= '0;
            last_reg       <= 1'b0;
            head_reg       <= START_HEAD_RST;
            acc_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_track_reg <= '0;
            pend_seek_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_track_reg  <= '0;
            out_seek_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            j_reg          <= j_next;
            idx_reg        <= idx_next;
            phase_reg      <= phase_next;
            ep_pend_reg    <= ep_pend_next;
            v_reg          <= v_next;
            last_reg       <= last_next;
            head_reg       <= head_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            pend_track_reg <= pend_track_next;
            pend_seek_reg  <= pend_seek_next;
            out_valid_reg  <= out_valid_next;
            out_track_reg  <= out_track_next;
            out_seek_reg   <= out_seek_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule
